// File: src/crs_pkg.sv
// Shared types, register indexes and constants of the cylinder restraint score unit.
package crs_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int SQRT_STEPS      = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GEOMETRY_MODE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_W           = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_X           = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROT_Y           = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_A        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTER_B        = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIUS          = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KAPPA_MAGNITUDE = 3'd7;

   localparam logic [1:0] MODE_GENERAL = 2'd0;
   localparam logic [1:0] MODE_AXIS_X  = 2'd1;
   localparam logic [1:0] MODE_AXIS_Y  = 2'd2;
   localparam logic [1:0] MODE_AXIS_Z  = 2'd3;

   localparam logic [62:0] SCORE_MAX = {63{1'b1}};

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               last_particle;
   } req_type;

   typedef struct packed {
      logic [62:0] particle_penalty;
      logic [62:0] total_score;
      logic        is_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         geometry_mode;
      logic signed [15:0] rot_w;
      logic signed [15:0] rot_x;
      logic signed [15:0] rot_y;
      logic signed [31:0] center_a;
      logic signed [31:0] center_b;
      logic [30:0]        radius;
      logic [31:0]        kappa_magnitude;
   } csr_type;

   typedef struct packed {
      logic [31:0] offset_a;
      logic [31:0] offset_b;
      logic        last_particle;
   } cross_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_ROTATE,
      FRONT_OFFSET,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BACK_IDLE,
      BACK_SQUARE_A,
      BACK_SQUARE_B,
      BACK_RADIUS,
      BACK_COMPARE,
      BACK_SQRT,
      BACK_DEV,
      BACK_KAPPA_HI,
      BACK_KAPPA_LO,
      BACK_PENALTY,
      BACK_ACCUM
   } back_state_type;

endpackage

// File: src/cylinder_restraint_score_unit.sv
// Top level of the cylinder restraint score unit: registers, front, queue and back.
//
// Usage: write the registers through csr_write/csr_index/csr_data while the unit
// is idle, then push one particle position per item on req_item (push, full).
// Each item yields one result on rsp_item (empty, pop): the particle's penalty,
// the running total including it and the last marker; the total clears after
// an item marked last.
// In the general mode the front part forms the rotation over 12 products on one
// shared 32 by 32 multiplier; axis modes select the coordinates directly. For a
// particle outside the radius the back part runs a bit-serial square root, which
// dominates its time. Each part works on one item at a time; the front takes a new
// position once it has pushed the last one into the queue.
// A queue of QUEUE_DEPTH items decouples the two parts, and the result register
// lets the back part start the next item while a result waits to be taken.
// If the receiver stalls, the back part halts at its accumulate step, the queue
// fills and full is raised. Reset is synchronous, clears the total and the
// queue, and restores the register defaults (axis along z, unit quaternion).
module cylinder_restraint_score_unit #(
   parameter int QUEUE_DEPTH = crs_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  crs_pkg::req_type                     req_item,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output crs_pkg::rsp_type                     rsp_item,
   input  logic                                 csr_write,
   input  logic [crs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [crs_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   crs_pkg::csr_type   csr_ff;
   crs_pkg::cross_type front_item, queue_item;
   logic               front_push, queue_full, queue_empty, back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.geometry_mode   <= crs_pkg::MODE_AXIS_Z;
         csr_ff.rot_w           <= 16'sd16384;
         csr_ff.rot_x           <= '0;
         csr_ff.rot_y           <= '0;
         csr_ff.center_a        <= '0;
         csr_ff.center_b        <= '0;
         csr_ff.radius          <= '0;
         csr_ff.kappa_magnitude <= '0;
      end else if (csr_write) begin
         case (csr_index)
            crs_pkg::CSR_GEOMETRY_MODE:   csr_ff.geometry_mode   <= csr_data[1:0];
            crs_pkg::CSR_ROT_W:           csr_ff.rot_w           <= csr_data[15:0];
            crs_pkg::CSR_ROT_X:           csr_ff.rot_x           <= csr_data[15:0];
            crs_pkg::CSR_ROT_Y:           csr_ff.rot_y           <= csr_data[15:0];
            crs_pkg::CSR_CENTER_A:        csr_ff.center_a        <= csr_data;
            crs_pkg::CSR_CENTER_B:        csr_ff.center_b        <= csr_data;
            crs_pkg::CSR_RADIUS:          csr_ff.radius          <= csr_data[30:0];
            crs_pkg::CSR_KAPPA_MAGNITUDE: csr_ff.kappa_magnitude <= csr_data;
            default: ;
         endcase
      end
   end

   crs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (front_push),
      .q_full   (queue_full),
      .q_item   (front_item)
   );

   crs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .item_in  (front_item),
      .full     (queue_full),
      .pop      (back_pop),
      .empty    (queue_empty),
      .item_out (queue_item)
   );

   crs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_empty   (queue_empty),
      .q_item    (queue_item),
      .q_pop     (back_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// File: src/crs_front.sv
// Front part: accepts a position, rotates or selects the cross coordinates, forms offsets.
module crs_front (
   input  logic              clock,
   input  logic              reset,
   input  crs_pkg::csr_type  csr,
   input  logic              req_push,
   output logic              req_full,
   input  crs_pkg::req_type  req_item,
   output logic              q_push,
   input  logic              q_full,
   output crs_pkg::cross_type q_item
);

   crs_pkg::front_state_type state_ff, state_in;
   crs_pkg::req_type         pos_ff;
   logic [3:0]               count_ff;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [31:0]       ww_ff, xx_ff, yy_ff, wy2_ff, wx2_ff, xy2_ff;
   logic signed [63:0]       sum_a_ff, sum_b_ff;
   logic signed [63:0]       diff_a_ff, diff_b_ff;
   logic signed [31:0]       mul_a, mul_b;
   logic signed [31:0]       c00, c01, c02, c10, c11, c12;
   logic signed [31:0]       w_ext, x_ext, y_ext;
   logic signed [63:0]       sel_a, sel_b, ext_x, ext_y, ext_z;
   logic signed [63:0]       round_a, round_b, cen_a, cen_b;

   function automatic logic [31:0] sat_mag(input logic signed [63:0] d);
      logic [63:0] mag;
      mag = d[63] ? (64'd0 - d) : d;
      return (|mag[63:32]) ? 32'hFFFF_FFFF : mag[31:0];
   endfunction

   assign w_ext = {{16{csr.rot_w[15]}}, csr.rot_w};
   assign x_ext = {{16{csr.rot_x[15]}}, csr.rot_x};
   assign y_ext = {{16{csr.rot_y[15]}}, csr.rot_y};

   // Rotation matrix rows in Q4.28; the quaternion's z part is zero.
   assign c00 = ww_ff + xx_ff - yy_ff;
   assign c01 = xy2_ff;
   assign c02 = wy2_ff;
   assign c10 = xy2_ff;
   assign c11 = ww_ff - xx_ff + yy_ff;
   assign c12 = -wx2_ff;

   always_comb begin
      case (count_ff)
         4'd0: begin
            mul_a = w_ext; mul_b = w_ext;
         end
         4'd1: begin
            mul_a = x_ext; mul_b = x_ext;
         end
         4'd2: begin
            mul_a = y_ext; mul_b = y_ext;
         end
         4'd3: begin
            mul_a = w_ext; mul_b = y_ext;
         end
         4'd4: begin
            mul_a = w_ext; mul_b = x_ext;
         end
         4'd5: begin
            mul_a = x_ext; mul_b = y_ext;
         end
         4'd6: begin
            mul_a = c00; mul_b = pos_ff.pos_x;
         end
         4'd7: begin
            mul_a = c02; mul_b = pos_ff.pos_z;
         end
         4'd8: begin
            mul_a = c11; mul_b = pos_ff.pos_y;
         end
         4'd9: begin
            mul_a = c12; mul_b = pos_ff.pos_z;
         end
         4'd10: begin
            mul_a = c01; mul_b = pos_ff.pos_y;
         end
         4'd11: begin
            mul_a = c10; mul_b = pos_ff.pos_x;
         end
         default: begin
            mul_a = '0; mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign ext_x   = {{32{pos_ff.pos_x[31]}}, pos_ff.pos_x};
   assign ext_y   = {{32{pos_ff.pos_y[31]}}, pos_ff.pos_y};
   assign ext_z   = {{32{pos_ff.pos_z[31]}}, pos_ff.pos_z};
   assign cen_a   = {{32{csr.center_a[31]}}, csr.center_a};
   assign cen_b   = {{32{csr.center_b[31]}}, csr.center_b};
   assign round_a = (sum_a_ff + 64'sd8192) >>> 14;
   assign round_b = (sum_b_ff + 64'sd8192) >>> 14;

   always_comb begin
      case (csr.geometry_mode)
         crs_pkg::MODE_GENERAL: begin
            sel_a = round_a; sel_b = round_b;
         end
         crs_pkg::MODE_AXIS_X: begin
            sel_a = ext_y; sel_b = ext_z;
         end
         crs_pkg::MODE_AXIS_Y: begin
            sel_a = ext_x; sel_b = ext_z;
         end
         default: begin
            sel_a = ext_x; sel_b = ext_y;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crs_pkg::FRONT_IDLE: begin
            if (req_push) begin
               state_in = (csr.geometry_mode == crs_pkg::MODE_GENERAL) ?
                          crs_pkg::FRONT_ROTATE : crs_pkg::FRONT_OFFSET;
            end
         end
         crs_pkg::FRONT_ROTATE: begin
            if (count_ff == 4'd12) state_in = crs_pkg::FRONT_OFFSET;
         end
         crs_pkg::FRONT_OFFSET: state_in = crs_pkg::FRONT_PUSH;
         crs_pkg::FRONT_PUSH: begin
            if (!q_full) state_in = crs_pkg::FRONT_IDLE;
         end
         default: state_in = crs_pkg::FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_full = (state_ff != crs_pkg::FRONT_IDLE);
      q_push   = (state_ff == crs_pkg::FRONT_PUSH) && !q_full;
      q_item.offset_a      = sat_mag(diff_a_ff);
      q_item.offset_b      = sat_mag(diff_b_ff);
      q_item.last_particle = pos_ff.last_particle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crs_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Each product is registered and consumed in the cycle after it is formed.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         crs_pkg::FRONT_IDLE: begin
            pos_ff   <= req_item;
            count_ff <= 4'd0;
            sum_a_ff <= '0;
            sum_b_ff <= '0;
         end
         crs_pkg::FRONT_ROTATE: begin
            count_ff <= count_ff + 4'd1;
            case (count_ff)
               4'd1: ww_ff  <= prod_ff[31:0];
               4'd2: xx_ff  <= prod_ff[31:0];
               4'd3: yy_ff  <= prod_ff[31:0];
               4'd4: wy2_ff <= {prod_ff[30:0], 1'b0};
               4'd5: wx2_ff <= {prod_ff[30:0], 1'b0};
               4'd6: xy2_ff <= {prod_ff[30:0], 1'b0};
               4'd7, 4'd8, 4'd11: sum_a_ff <= sum_a_ff + (prod_ff >>> 14);
               4'd9, 4'd10, 4'd12: sum_b_ff <= sum_b_ff + (prod_ff >>> 14);
               default: ;
            endcase
         end
         crs_pkg::FRONT_OFFSET: begin
            diff_a_ff <= sel_a - cen_a;
            diff_b_ff <= sel_b - cen_b;
         end
         default: ;
      endcase
   end

endmodule

// File: src/crs_queue.sv
// Short queue of offset items between the front and the back part.
module crs_queue #(
   parameter int DEPTH = crs_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crs_pkg::cross_type item_in,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output crs_pkg::cross_type item_out
);

   localparam int PTR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   crs_pkg::cross_type     slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   head_ff, tail_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   function automatic logic [PTR_WIDTH-1:0] advance(input logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty    = (count_ff == '0);
   assign item_out = slot_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) tail_ff <= advance(tail_ff);
         if (pop)  head_ff <= advance(head_ff);
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[tail_ff] <= item_in;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("item pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("item popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

// File: src/crs_back.sv
// Back part: radial distance, square root, penalty and running total.
module crs_back (
   input  logic               clock,
   input  logic               reset,
   input  crs_pkg::csr_type   csr,
   input  logic               q_empty,
   input  crs_pkg::cross_type q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output crs_pkg::rsp_type   rsp_item
);

   crs_pkg::back_state_type state_ff, state_in;
   crs_pkg::cross_type      item_ff;
   crs_pkg::rsp_type        out_ff;
   logic                    out_valid_ff;
   logic [63:0]             prod_ff, prod_in;
   logic [63:0]             sa_ff, radial_ff, dev2_ff, hi_ff;
   logic [63:0]             rem_ff, root_ff;
   logic [4:0]              step_ff;
   logic [62:0]             pen_ff, sum_ff;
   logic [31:0]             mul_a, mul_b, dev, radius_ext;
   logic [64:0]             radial_sum;
   logic [63:0]             pen_sum, total_sum, bit_val, trial;
   logic [5:0]              shift_amt;
   logic [62:0]             total;
   logic                    out_write;

   assign radius_ext = {1'b0, csr.radius};
   assign dev        = root_ff[31:0] - radius_ext;
   assign shift_amt  = 6'd62 - {step_ff, 1'b0};
   assign bit_val    = 64'd1 << shift_amt;
   assign trial      = root_ff + bit_val;
   assign radial_sum = {1'b0, sa_ff} + {1'b0, prod_ff};
   assign pen_sum    = hi_ff + {32'd0, prod_ff[63:32]};
   assign total_sum  = {1'b0, sum_ff} + {1'b0, pen_ff};
   assign total      = total_sum[63] ? crs_pkg::SCORE_MAX : total_sum[62:0];
   assign prod_in    = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crs_pkg::BACK_IDLE: begin
            if (!q_empty) state_in = crs_pkg::BACK_SQUARE_A;
         end
         crs_pkg::BACK_SQUARE_A: state_in = crs_pkg::BACK_SQUARE_B;
         crs_pkg::BACK_SQUARE_B: state_in = crs_pkg::BACK_RADIUS;
         crs_pkg::BACK_RADIUS:   state_in = crs_pkg::BACK_COMPARE;
         crs_pkg::BACK_COMPARE: begin
            state_in = (radial_ff > prod_ff) ? crs_pkg::BACK_SQRT : crs_pkg::BACK_ACCUM;
         end
         crs_pkg::BACK_SQRT: begin
            if (step_ff == 5'(crs_pkg::SQRT_STEPS - 1)) state_in = crs_pkg::BACK_DEV;
         end
         crs_pkg::BACK_DEV:      state_in = crs_pkg::BACK_KAPPA_HI;
         crs_pkg::BACK_KAPPA_HI: state_in = crs_pkg::BACK_KAPPA_LO;
         crs_pkg::BACK_KAPPA_LO: state_in = crs_pkg::BACK_PENALTY;
         crs_pkg::BACK_PENALTY:  state_in = crs_pkg::BACK_ACCUM;
         crs_pkg::BACK_ACCUM: begin
            if (!out_valid_ff || rsp_pop) state_in = crs_pkg::BACK_IDLE;
         end
         default: state_in = crs_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = (state_ff == crs_pkg::BACK_IDLE) && !q_empty;
      out_write = (state_ff == crs_pkg::BACK_ACCUM) && (!out_valid_ff || rsp_pop);
      rsp_empty = !out_valid_ff;
      rsp_item  = out_ff;
      case (state_ff)
         crs_pkg::BACK_SQUARE_A: begin
            mul_a = item_ff.offset_a; mul_b = item_ff.offset_a;
         end
         crs_pkg::BACK_SQUARE_B: begin
            mul_a = item_ff.offset_b; mul_b = item_ff.offset_b;
         end
         crs_pkg::BACK_RADIUS: begin
            mul_a = radius_ext; mul_b = radius_ext;
         end
         crs_pkg::BACK_DEV: begin
            mul_a = dev; mul_b = dev;
         end
         crs_pkg::BACK_KAPPA_HI: begin
            mul_a = csr.kappa_magnitude; mul_b = prod_ff[63:32];
         end
         crs_pkg::BACK_KAPPA_LO: begin
            mul_a = csr.kappa_magnitude; mul_b = dev2_ff[31:0];
         end
         default: begin
            mul_a = '0; mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crs_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (out_write) begin
            out_valid_ff <= 1'b1;
            sum_ff       <= item_ff.last_particle ? '0 : total;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         crs_pkg::BACK_IDLE:     item_ff <= q_item;
         crs_pkg::BACK_SQUARE_B: sa_ff   <= prod_ff;
         crs_pkg::BACK_RADIUS: begin
            radial_ff <= radial_sum[64] ? '1 : radial_sum[63:0];
         end
         crs_pkg::BACK_COMPARE: begin
            rem_ff  <= radial_ff;
            root_ff <= '0;
            step_ff <= '0;
            pen_ff  <= '0;
         end
         // One result bit per cycle, highest first.
         crs_pkg::BACK_SQRT: begin
            step_ff <= step_ff + 5'd1;
            if (rem_ff >= trial) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_val;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
         crs_pkg::BACK_KAPPA_HI: dev2_ff <= prod_ff;
         crs_pkg::BACK_KAPPA_LO: hi_ff   <= prod_ff;
         crs_pkg::BACK_PENALTY: begin
            pen_ff <= pen_sum[63] ? crs_pkg::SCORE_MAX : pen_sum[62:0];
         end
         default: ;
      endcase
      if (out_write) begin
         out_ff.particle_penalty <= pen_ff;
         out_ff.total_score      <= total;
         out_ff.is_last          <= item_ff.last_particle;
      end
   end

   a_result_from_accum: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == crs_pkg::BACK_ACCUM))
      else $error("result appeared without an accumulate step");

endmodule

// File: bench/tb_cylinder_restraint_score_unit.sv
// Self-checking testbench for the cylinder restraint score unit with a built-in score predictor.
module tb_cylinder_restraint_score_unit;
   import crs_pkg::*;

   localparam int  LIMIT_CYCLES  = 1000000;
   localparam int  SETTLE_CYCLES = 100;
   localparam int  PHASES        = 8;
   localparam int  PHASE_ITEMS   = 160;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   req_type                    req_item = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   rsp_type                    rsp_item;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   cylinder_restraint_score_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   typedef struct {
      bit                         is_reg;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [31:0]                data;
      req_type                    item;
      bit                         typed;
      rsp_type                    want;
   } stim_row_type;

   csr_type      model_regs;
   logic [62:0]  running_total;
   rsp_type      pending_scores[$];
   stim_row_type stim_table[$];
   int           errors = 0;
   int           cycles = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;

   function automatic longint rotate_row(longint c0, longint c1, longint c2,
                                         longint px, longint py, longint pz);
      longint s;
      s = ((c0 * px) >>> 14) + ((c1 * py) >>> 14) + ((c2 * pz) >>> 14);
      return (s + 8192) >>> 14;
   endfunction

   function automatic logic [63:0] clamp_offset(longint d);
      logic [63:0] u;
      u = (d < 0) ? -d : d;
      return (u > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : u;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Works out the result of one accepted item and advances the running total.
   function automatic rsp_type score_particle(req_type it);
      longint      px, py, pz, w, x, y, a, b, ww, xx, yy, xy2;
      logic [63:0] ua, ub, sa, sb, radial, rad, dev, dev2, kap, penalty;
      rsp_type     r;
      px = it.pos_x; py = it.pos_y; pz = it.pos_z;
      w = model_regs.rot_w; x = model_regs.rot_x; y = model_regs.rot_y;
      case (model_regs.geometry_mode)
         MODE_GENERAL: begin
            ww = w * w; xx = x * x; yy = y * y; xy2 = 2 * x * y;
            a = rotate_row(ww + xx - yy, xy2, 2 * w * y, px, py, pz);
            b = rotate_row(xy2, ww - xx + yy, -2 * w * x, px, py, pz);
         end
         MODE_AXIS_X: begin a = py; b = pz; end
         MODE_AXIS_Y: begin a = px; b = pz; end
         default:     begin a = px; b = py; end
      endcase
      ua = clamp_offset(a - longint'(model_regs.center_a));
      ub = clamp_offset(b - longint'(model_regs.center_b));
      sa = ua * ua;
      sb = ub * ub;
      radial = (sa > ~sb) ? '1 : sa + sb;
      rad = 64'(model_regs.radius);
      kap = 64'(model_regs.kappa_magnitude);
      penalty = 0;
      if (radial > rad * rad) begin
         dev = root_floor(radial) - rad;
         dev2 = dev * dev;
         penalty = kap * (dev2 >> 32) + ((kap * (dev2 & 64'hFFFF_FFFF)) >> 32);
         if (penalty > 64'(SCORE_MAX)) penalty = 64'(SCORE_MAX);
      end
      running_total = (penalty[62:0] > SCORE_MAX - running_total) ?
                      SCORE_MAX : running_total + penalty[62:0];
      r.particle_penalty = penalty[62:0];
      r.total_score = running_total;
      r.is_last = it.last_particle;
      if (it.last_particle) running_total = '0;
      return r;
   endfunction

   task automatic wait_idle();
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One write per edge; the caller lowers the enable after the last of a group.
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         CSR_GEOMETRY_MODE:   model_regs.geometry_mode = val[1:0];
         CSR_ROT_W:           model_regs.rot_w = val[15:0];
         CSR_ROT_X:           model_regs.rot_x = val[15:0];
         CSR_ROT_Y:           model_regs.rot_y = val[15:0];
         CSR_CENTER_A:        model_regs.center_a = val;
         CSR_CENTER_B:        model_regs.center_b = val;
         CSR_RADIUS:          model_regs.radius = val[30:0];
         CSR_KAPPA_MAGNITUDE: model_regs.kappa_magnitude = val;
         default: ;
      endcase
   endtask

   task automatic send_item(req_type it, bit typed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      predicted = score_particle(it);
      pending_scores.push_back(typed ? want : predicted);
   endtask

   function automatic logic [31:0] spread_value();
      return $unsigned($signed($urandom) >>> $urandom_range(31));
   endfunction

   function automatic req_type random_particle();
      req_type it;
      if ($urandom_range(3) == 0) begin
         it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
      end else begin
         it.pos_x = model_regs.center_a + spread_value();
         it.pos_y = model_regs.center_b + spread_value();
         it.pos_z = spread_value();
      end
      it.last_particle = ($urandom_range(7) == 0);
      return it;
   endfunction

   function automatic logic [31:0] random_rot();
      return 32'($urandom_range(32768)) - 32'd16384;
   endfunction

   function automatic req_type particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic last);
      req_type it;
      it.pos_x = x; it.pos_y = y; it.pos_z = z; it.last_particle = last;
      return it;
   endfunction

   task automatic add_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] val);
      stim_row_type row;
      row = '{is_reg: 1'b1, index: idx, data: val, item: '0, typed: 1'b0, want: '0};
      stim_table.push_back(row);
   endtask

   task automatic add_item(req_type it, bit typed = 1'b0, logic [62:0] pen = '0,
                           logic [62:0] tot = '0);
      stim_row_type row;
      row = '{is_reg: 1'b0, index: '0, data: '0, item: it, typed: typed,
              want: '{particle_penalty: pen, total_score: tot, is_last: it.last_particle}};
      stim_table.push_back(row);
   endtask

   // Result checker; pop is redrawn every edge.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_scores.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_item);
            errors++;
         end else begin
            if (rsp_item.particle_penalty !== pending_scores[0].particle_penalty) begin
               $display("%0t: particle_penalty expected %h actual %h", $time,
                        pending_scores[0].particle_penalty, rsp_item.particle_penalty);
               errors++;
            end
            if (rsp_item.total_score !== pending_scores[0].total_score) begin
               $display("%0t: total_score expected %h actual %h", $time,
                        pending_scores[0].total_score, rsp_item.total_score);
               errors++;
            end
            if (rsp_item.is_last !== pending_scores[0].is_last) begin
               $display("%0t: is_last expected %b actual %b", $time,
                        pending_scores[0].is_last, rsp_item.is_last);
               errors++;
            end
            void'(pending_scores.pop_front());
         end
      end
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb_cylinder_restraint_score_unit: FAIL");
         $finish;
      end
   end

   initial begin
      bit last_was_reg;
      model_regs = '{geometry_mode: MODE_AXIS_Z, rot_w: 16'sd16384, default: '0};
      running_total = '0;

      // Defaults: no spring, so nothing scores even at the extremes.
      add_item(particle(32'h0, 32'h0, 32'h0, 1'b0), 1'b1, 63'd0, 63'd0);
      add_item(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1),
               1'b1, 63'd0, 63'd0);
      // Unit spring, one unit out from a zero radius.
      add_reg(CSR_KAPPA_MAGNITUDE, 32'h0001_0000);
      add_item(particle(32'h0001_0000, 32'h0, 32'h0, 1'b1), 1'b1, 63'h10000, 63'h10000);
      // Widest offset with the stiffest spring saturates penalty and total.
      add_reg(CSR_CENTER_A, 32'h8000_0000);
      add_reg(CSR_KAPPA_MAGNITUDE, 32'hFFFF_FFFF);
      add_item(particle(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0), 1'b1, SCORE_MAX, SCORE_MAX);
      add_item(particle(32'h0, 32'h0, 32'h0, 1'b1));
      add_item(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      // Largest radius.
      add_reg(CSR_CENTER_A, 32'h0);
      add_reg(CSR_RADIUS, 32'h7FFF_FFFF);
      add_item(particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 1'b0));
      add_item(particle(32'h4000_0000, 32'h0, 32'h0, 1'b1));
      add_reg(CSR_RADIUS, 32'h0002_8000);
      add_reg(CSR_KAPPA_MAGNITUDE, 32'h0003_4000);
      add_reg(CSR_CENTER_B, 32'hFFFF_0000);
      add_item(particle(32'h0005_0000, 32'hFFFA_0000, 32'h0009_0000, 1'b0));
      add_reg(CSR_GEOMETRY_MODE, 32'(MODE_AXIS_X));
      add_item(particle(32'h0005_0000, 32'hFFFA_0000, 32'h0009_0000, 1'b0));
      add_reg(CSR_GEOMETRY_MODE, 32'(MODE_AXIS_Y));
      add_item(particle(32'h0005_0000, 32'hFFFA_0000, 32'h0009_0000, 1'b1));
      // General mode: identity first, then non-unit quaternions at the extremes.
      add_reg(CSR_GEOMETRY_MODE, 32'(MODE_GENERAL));
      add_item(particle(32'h0005_0000, 32'hFFFA_0000, 32'h0009_0000, 1'b0));
      add_reg(CSR_ROT_W, 32'hFFFF_C000);
      add_reg(CSR_ROT_X, 32'h0000_4000);
      add_reg(CSR_ROT_Y, 32'h0000_4000);
      add_item(particle(32'h0005_0000, 32'hFFFA_0000, 32'h0009_0000, 1'b0));
      add_item(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
      add_reg(CSR_ROT_X, 32'hFFFF_C000);
      add_reg(CSR_ROT_Y, 32'hFFFF_C000);
      add_item(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
      add_reg(CSR_ROT_W, 32'h0000_2D41);
      add_reg(CSR_ROT_X, 32'h0000_2D41);
      add_reg(CSR_ROT_Y, 32'h0);
      add_item(particle(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      last_was_reg = 1'b0;
      foreach (stim_table[i]) begin
         if (stim_table[i].is_reg) begin
            if (!last_was_reg) begin
               req_push <= 1'b0;
               wait_idle();
            end
            write_reg(stim_table[i].index, stim_table[i].data);
            last_was_reg = 1'b1;
         end else begin
            if (last_was_reg) begin
               csr_write <= 1'b0;
               @(posedge clock);
            end
            send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
            last_was_reg = 1'b0;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         // Sender holds off until every result is back before each new setting.
         req_push <= 1'b0;
         wait_idle();
         write_reg(CSR_GEOMETRY_MODE, (p < 4) ? 32'(p) :
                   (($urandom_range(1) == 0) ? 32'(MODE_GENERAL) : 32'($urandom_range(3))));
         write_reg(CSR_ROT_W, (p == 4) ? 32'h0000_4000 : random_rot());
         write_reg(CSR_ROT_X, (p == 5) ? 32'hFFFF_C000 : random_rot());
         write_reg(CSR_ROT_Y, random_rot());
         write_reg(CSR_CENTER_A, (p == 6) ? 32'h7FFF_FFFF : spread_value());
         write_reg(CSR_CENTER_B, (p == 7) ? 32'h8000_0000 : spread_value());
         write_reg(CSR_RADIUS, (p == 2) ? 32'h0 : (p == 3) ? 32'h7FFF_FFFF :
                   ($urandom >> $urandom_range(1, 31)));
         write_reg(CSR_KAPPA_MAGNITUDE, (p == 1) ? 32'hFFFF_FFFF :
                   ($urandom >> $urandom_range(31)));
         csr_write <= 1'b0;
         idle_pct  = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 70 : 14) : 0;
         stall_pct = (p % 4 == 2) ? 70 : (p % 4 == 3) ? 14 : 0;
         @(posedge clock);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(random_particle(), 1'b0, '0);
      end

      req_push <= 1'b0;
      wait_idle();
      if (errors == 0)
         $display("tb_cylinder_restraint_score_unit: PASS");
      else
         $display("tb_cylinder_restraint_score_unit: FAIL");
      $finish;
   end

endmodule

// File: files.f
src/crs_pkg.sv
src/crs_front.sv
src/crs_queue.sv
src/crs_back.sv
src/cylinder_restraint_score_unit.sv
bench/tb_cylinder_restraint_score_unit.sv
